// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the allele counter.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is asserted (active-low reset).
`define GAC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked assertion that is also checked during reset.
`define GAC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GAC_ASSERT(lbl, clk, rstn, prop, msg)
`define GAC_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/gac_pkg.sv =====
// Package of the allele counter: sizes, codes, command types and the code mapping.
// Depends on nothing; used by every other .sv file by scoped names.
package gac_pkg;

  localparam int MAX_INDIVIDUALS = 4096;
  localparam int COUNT_WIDTH     = 20;
  localparam int LANES           = 4;
  localparam int ROWS            = MAX_INDIVIDUALS / LANES;
  localparam int ROW_W           = $clog2(ROWS);
  localparam int IND_W           = 12;
  localparam int CFG_W           = 13;
  localparam int BYTE_W          = 8;
  localparam int QDEPTH          = 2;
  localparam int QPTR_W          = $clog2(QDEPTH);
  localparam int QCNT_W          = $clog2(QDEPTH + 1);

  localparam logic [CFG_W-1:0] CFG_RESET    = 13'd4096;
  localparam logic [1:0]       CODE_MISSING = 2'd3;
  localparam logic             OP_ACC       = 1'b0;
  localparam logic             OP_READ      = 1'b1;

  typedef logic [COUNT_WIDTH-1:0]            count_t;
  typedef logic [LANES-1:0][COUNT_WIDTH-1:0] row_t;
  typedef logic [LANES-1:0][1:0]             adds_t;

  typedef struct packed {
    logic             is_read;
    logic [ROW_W-1:0] row;
    logic [1:0]       lane;
    adds_t            adds;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic logic [1:0] code_to_alleles(input logic [1:0] code, input logic inv);
    logic [1:0] res;
    if (code == CODE_MISSING) begin
      res = 2'd0;
    end else if (inv) begin
      res = 2'd2 - code;
    end else begin
      res = code;
    end
    return res;
  endfunction

endpackage

// ===== hdl/gac_ifs.sv =====
// Channel interfaces of the allele counter: input items, results, configuration.
// Depends on gac_pkg.
interface gac_in_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [gac_pkg::BYTE_W-1:0]     packed_byte;
  logic [9:0]                     byte_index;
  logic                           row_selected;
  logic                           invert;
  logic [gac_pkg::IND_W-1:0]      individual_index;

  modport source(output valid, opcode, packed_byte, byte_index, row_selected, invert,
                 individual_index, input ready);
  modport sink(input valid, opcode, packed_byte, byte_index, row_selected, invert,
               individual_index, output ready);
endinterface

interface gac_out_if;
  logic                            valid;
  logic                            ready;
  logic [gac_pkg::COUNT_WIDTH-1:0] allele_count;

  modport source(output valid, allele_count, input ready);
  modport sink(input valid, allele_count, output ready);
endinterface

interface gac_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [gac_pkg::CFG_W-1:0] individuals_in_use;

  modport source(output valid, individuals_in_use, input ready);
  modport sink(input valid, individuals_in_use, output ready);
endinterface

// ===== hdl/packed_genotype_allele_counter.sv =====
// Packed genotype allele counter: one saturating 20-bit counter per individual, 4096 in all.
// The back end finishes one command (row write-back or result load) before it takes the next.
// A read item's result passes the command queue, the read row register and the result register.
// Reset: synchronous, active low; a clearing pass then zeroes the counter memory, one row a
// cycle through all 1024 rows, during which in_ch.ready stays low (config writes still taken).
// Depends on gac_pkg, gac_ifs, gac_front, gac_queue, gac_back, assert_macros.svh.
`include "assert_macros.svh"

module packed_genotype_allele_counter (
  input  logic       clk,
  input  logic       rst_n,
  gac_in_if.sink     in_ch,
  gac_out_if.source  out_ch,
  gac_cfg_if.sink    cfg_ch
);

  // Front/back handoff: commands travel through a two-entry queue so each side stalls alone.
  gac_pkg::cmd_t      push_cmd;
  gac_pkg::cmd_t      head;
  gac_pkg::back_stat_t stat;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;

  // Classify items: reads always go on, accumulates only when they could change a counter.
  gac_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .stat     (stat),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  gac_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Execute commands: read the row, then either write back the four sums or load the result.
  gac_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .stat    (stat),
    .out_ch  (out_ch)
  );

  // Reset must start the clearing pass.
  `GAC_ASSERT_NR(a_reset_clears, clk, !rst_n |=> stat.clearing, "clearing pass not started")
  // No item may enter while the counter memory is being cleared.
  `GAC_ASSERT(a_no_accept_clear, clk, rst_n, stat.clearing |-> !in_ch.ready, "item during clear")
  // The back end pops only a filled queue, and the front never pushes a full one.
  `GAC_ASSERT(a_pop_nonempty, clk, rst_n, pop |-> !q_empty, "pop from empty queue")
  `GAC_ASSERT(a_push_notfull, clk, rst_n, push |-> !q_full, "push into full queue")
  // An accepted accumulate of an unselected row must leave no command behind.
  `GAC_ASSERT(a_drop_unsel, clk, rst_n,
              (in_ch.valid && in_ch.ready && (in_ch.opcode == gac_pkg::OP_ACC)
               && !in_ch.row_selected) |-> !push, "unselected row queued")

endmodule

// ===== hdl/gac_front.sv =====
// Front end: holds the individual-count register, accepts items and turns them into commands.
// Depends on gac_pkg and gac_ifs.
module gac_front (
  input  logic                clk,
  input  logic                rst_n,
  gac_in_if.sink              in_ch,
  gac_cfg_if.sink             cfg_ch,
  input  gac_pkg::back_stat_t stat,
  input  logic                q_full,
  output logic                push,
  output gac_pkg::cmd_t       push_cmd
);

  logic [gac_pkg::CFG_W-1:0] ind_use_r;
  logic [gac_pkg::CFG_W-1:0] ind_use_nxt;
  gac_pkg::adds_t            adds;
  logic                      accept;
  logic [gac_pkg::IND_W-1:0] ind;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !stat.clearing && !q_full;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    ind_use_nxt = ind_use_r;
    if (cfg_ch.valid) begin
      ind_use_nxt = cfg_ch.individuals_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ind_use_r <= gac_pkg::CFG_RESET;
    end else begin
      ind_use_r <= ind_use_nxt;
    end
  end

  // Map each code to an allele count; drop positions past the individual count.
  always_comb begin
    ind = '0;
    for (int p = 0; p < gac_pkg::LANES; p++) begin
      ind = {in_ch.byte_index, 2'(p)};
      if ({1'b0, ind} < ind_use_r) begin
        adds[p] = gac_pkg::code_to_alleles(in_ch.packed_byte[2*p +: 2], in_ch.invert);
      end else begin
        adds[p] = 2'd0;
      end
    end
  end

  always_comb begin
    push_cmd.is_read = (in_ch.opcode == gac_pkg::OP_READ);
    push_cmd.row     = push_cmd.is_read ? in_ch.individual_index[gac_pkg::IND_W-1:2]
                                        : in_ch.byte_index;
    push_cmd.lane    = in_ch.individual_index[1:0];
    push_cmd.adds    = adds;
    // Unselected rows and all-zero adds change nothing: drop them here.
    push = accept && (push_cmd.is_read || (in_ch.row_selected && (|adds)));
  end

endmodule

// ===== hdl/gac_queue.sv =====
// Small command queue between the front end and the counter back end.
// Depends on gac_pkg.
module gac_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gac_pkg::cmd_t push_cmd,
  input  logic          pop,
  output gac_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  gac_pkg::cmd_t              slots_r [gac_pkg::QDEPTH];
  logic [gac_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [gac_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [gac_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == gac_pkg::QCNT_W'(gac_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slots_r[rd_ptr_r];

  function automatic logic [gac_pkg::QPTR_W-1:0] bump(input logic [gac_pkg::QPTR_W-1:0] p);
    logic [gac_pkg::QPTR_W-1:0] r;
    if (p == gac_pkg::QPTR_W'(gac_pkg::QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + gac_pkg::QCNT_W'(push) - gac_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/gac_back.sv =====
// Back end: counter memory with clearing pass, read-modify-write and the result register.
// Depends on gac_pkg and gac_ifs.
module gac_back (
  input  logic                clk,
  input  logic                rst_n,
  input  gac_pkg::cmd_t       head,
  input  logic                q_empty,
  output logic                pop,
  output gac_pkg::back_stat_t stat,
  gac_out_if.source           out_ch
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  gac_pkg::row_t             mem [gac_pkg::ROWS];
  gac_pkg::row_t             rd_r;
  logic                      state_r, state_nxt;
  logic                      clr_busy_r, clr_busy_nxt;
  logic [gac_pkg::ROW_W-1:0] clr_addr_r, clr_addr_nxt;
  gac_pkg::cmd_t             cmd_r;
  logic                      out_valid_r, out_valid_nxt;
  gac_pkg::count_t           out_data_r;
  logic                      load_out;
  logic                      out_free;
  logic                      we;
  logic [gac_pkg::ROW_W-1:0] wa;
  gac_pkg::row_t             wd;
  gac_pkg::row_t             upd;
  logic [gac_pkg::COUNT_WIDTH:0] sum;

  assign stat.clearing       = clr_busy_r;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.allele_count = out_data_r;

  assign pop      = (state_r == ST_IDLE) && !clr_busy_r && !q_empty;
  assign out_free = !out_valid_r || out_ch.ready;
  assign load_out = (state_r == ST_EXEC) && cmd_r.is_read && out_free;

  // Saturating add per lane.
  always_comb begin
    sum = '0;
    for (int p = 0; p < gac_pkg::LANES; p++) begin
      sum = {1'b0, rd_r[p]} + (gac_pkg::COUNT_WIDTH + 1)'(cmd_r.adds[p]);
      upd[p] = sum[gac_pkg::COUNT_WIDTH] ? {gac_pkg::COUNT_WIDTH{1'b1}}
                                         : sum[gac_pkg::COUNT_WIDTH-1:0];
    end
  end

  always_comb begin
    we = clr_busy_r || ((state_r == ST_EXEC) && !cmd_r.is_read);
    wa = clr_busy_r ? clr_addr_r : cmd_r.row;
    wd = clr_busy_r ? '0 : upd;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_busy_nxt  = clr_busy_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == gac_pkg::ROW_W'(gac_pkg::ROWS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!cmd_r.is_read) begin
          state_nxt = ST_IDLE;
        end else if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head;
    end
    if (load_out) begin
      out_data_r <= rd_r[cmd_r.lane];
    end
  end

  // Counter memory: one row of four counters per genotype byte.
  // Hold the read row while the command executes, even if the result waits.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (pop) begin
      rd_r <= mem[head.row];
    end
  end

endmodule

// ===== test/genotype_tb_pkg.sv =====
// Testbench types for the allele counter: the input item record and the count scoreboard.
// Depends on gac_pkg for widths and codes; used by test/testbench.sv.
package genotype_tb_pkg;

  typedef struct {
    logic                          opcode;
    logic [gac_pkg::BYTE_W-1:0]    packed_byte;
    logic [9:0]                    byte_index;
    logic                          row_selected;
    logic                          invert;
    logic [gac_pkg::IND_W-1:0]     individual_index;
  } genotype_item_t;

  class allele_scoreboard;
    gac_pkg::count_t           tally [gac_pkg::MAX_INDIVIDUALS];
    logic [gac_pkg::CFG_W-1:0] counted_individuals;
    gac_pkg::count_t           owed_counts [$];
    int                        failures;

    function new();
      foreach (tally[i]) tally[i] = '0;
      counted_individuals = gac_pkg::CFG_RESET;
      failures = 0;
    endfunction

    function void set_individuals(input logic [gac_pkg::CFG_W-1:0] n);
      counted_individuals = n;
    endfunction

    function int pending();
      return owed_counts.size();
    endfunction

    // Apply one accepted item: a read owes the current count, an accumulate updates tallies.
    function void note_input(input genotype_item_t it);
      int unsigned                  ind;
      logic [1:0]                   code;
      logic [1:0]                   gain;
      logic [gac_pkg::COUNT_WIDTH:0] sum;
      if (it.opcode == gac_pkg::OP_READ) begin
        owed_counts.push_back(tally[it.individual_index]);
        return;
      end
      if (!it.row_selected) return;
      for (int lane = 0; lane < gac_pkg::LANES; lane++) begin
        ind = gac_pkg::LANES * it.byte_index + lane;
        if (ind >= counted_individuals || ind >= gac_pkg::MAX_INDIVIDUALS) continue;
        code = it.packed_byte[2*lane +: 2];
        if (code == gac_pkg::CODE_MISSING) begin
          gain = 2'd0;
        end else if (it.invert) begin
          gain = 2'd2 - code;
        end else begin
          gain = code;
        end
        sum = {1'b0, tally[ind]} + gain;
        // clamp at the all-ones count
        tally[ind] = sum[gac_pkg::COUNT_WIDTH] ? '1 : sum[gac_pkg::COUNT_WIDTH-1:0];
      end
    endfunction

    function void check_result(input gac_pkg::count_t got);
      gac_pkg::count_t want;
      if (owed_counts.size() == 0) begin
        failures++;
        if (failures <= 10) $display("count %0d arrived with no read outstanding", got);
        return;
      end
      want = owed_counts.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) $display("allele_count mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

endpackage

// ===== test/testbench.sv =====
// Top-level testbench of the packed genotype allele counter: drives items and register
// writes, checks every read result. Depends on gac_pkg, gac_ifs and genotype_tb_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;

  gac_in_if  in_ch ();
  gac_out_if out_ch ();
  gac_cfg_if cfg_ch ();

  packed_genotype_allele_counter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  genotype_tb_pkg::allele_scoreboard sb = new();

  // Gaps on both channels are on while this is set; cleared for back-to-back stretches.
  bit idle_on = 1'b1;
  // Long output hold, in cycles, picked up by the result sink.
  int hold_request = 0;

  // 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic genotype_tb_pkg::genotype_item_t acc_item(input logic [7:0] b,
                                                               input logic [9:0] idx,
                                                               input logic sel,
                                                               input logic inv);
    genotype_tb_pkg::genotype_item_t it;
    it.opcode           = gac_pkg::OP_ACC;
    it.packed_byte      = b;
    it.byte_index       = idx;
    it.row_selected     = sel;
    it.invert           = inv;
    it.individual_index = gac_pkg::IND_W'($urandom);  // ignored by an accumulate
    return it;
  endfunction

  function automatic genotype_tb_pkg::genotype_item_t read_item(
      input logic [gac_pkg::IND_W-1:0] who);
    genotype_tb_pkg::genotype_item_t it;
    it.opcode           = gac_pkg::OP_READ;
    it.individual_index = who;
    // fill the unused fields with noise
    it.packed_byte      = gac_pkg::BYTE_W'($urandom);
    it.byte_index       = 10'($urandom);
    it.row_selected     = 1'($urandom);
    it.invert           = 1'($urandom);
    return it;
  endfunction

  // Keep most accumulates on the first 16 bytes (individuals 0..63), most reads on 0..72,
  // so reads hit bumped counters; a tenth of the items roam the whole range.
  function automatic genotype_tb_pkg::genotype_item_t random_item();
    genotype_tb_pkg::genotype_item_t it;
    logic [9:0]                      idx;
    logic [gac_pkg::IND_W-1:0]       who;
    if ($urandom_range(0, 99) < 55) begin
      idx = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
      it  = acc_item(8'($urandom), idx, ($urandom_range(0, 9) != 0), 1'($urandom));
    end else begin
      who = ($urandom_range(0, 9) == 0) ? gac_pkg::IND_W'($urandom)
                                        : gac_pkg::IND_W'($urandom_range(0, 72));
      it  = read_item(who);
    end
    return it;
  endfunction

  function automatic logic [gac_pkg::CFG_W-1:0] pick_individuals();
    case ($urandom_range(0, 7))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return gac_pkg::CFG_RESET;
      end
      3: begin
        return gac_pkg::CFG_W'($urandom);
      end
      default: begin
        return gac_pkg::CFG_W'($urandom_range(1, 72));
      end
    endcase
  endfunction

  // Offer one item after an optional gap and hold it until the block takes it.
  task automatic send_item(input genotype_tb_pkg::genotype_item_t it);
    int gap;
    gap = idle_on ? gap_len() : 0;
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.opcode           <= it.opcode;
    in_ch.packed_byte      <= it.packed_byte;
    in_ch.byte_index       <= it.byte_index;
    in_ch.row_selected     <= it.row_selected;
    in_ch.invert           <= it.invert;
    in_ch.individual_index <= it.individual_index;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  // Drop valid, wait for every owed count, then give trailing accumulates time to land.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_individuals(input logic [gac_pkg::CFG_W-1:0] n);
    drain();
    cfg_ch.valid              <= 1'b1;
    cfg_ch.individuals_in_use <= n;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.set_individuals(n);
  endtask

  // Result sink: check on every handshake, then pick ready for the next cycle.
  initial begin : result_sink
    int stall;
    stall        = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.allele_count);
      if (hold_request != 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_on) stall = gap_len();
      end
    end
  end

  initial begin : stimulus
    rst_n                     = 1'b0;
    in_ch.valid               = 1'b0;
    in_ch.opcode              = gac_pkg::OP_ACC;
    in_ch.packed_byte         = '0;
    in_ch.byte_index          = '0;
    in_ch.row_selected        = 1'b0;
    in_ch.invert              = 1'b0;
    in_ch.individual_index    = '0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.individuals_in_use = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // The clearing pass still accepts register writes.
    write_individuals(gac_pkg::CFG_RESET);

    // Directed: mapping of all four codes, both polarities, unselected rows, edge bytes.
    send_item(read_item(12'd0));
    send_item(acc_item(8'hE4, 10'd0, 1'b1, 1'b0));     // codes 0,1,2,missing
    send_item(acc_item(8'hE4, 10'd0, 1'b1, 1'b1));     // same codes inverted
    send_item(acc_item(8'hFF, 10'd0, 1'b0, 1'b0));     // unselected row
    send_item(acc_item(8'h00, 10'd0, 1'b0, 1'b1));     // unselected, would add 2 each
    send_item(acc_item(8'hAA, 10'd1023, 1'b1, 1'b0));  // last byte of the row
    send_item(acc_item(8'hFF, 10'd1023, 1'b1, 1'b1));  // all missing, inverted
    send_item(read_item(12'd0));
    send_item(read_item(12'd1));
    send_item(read_item(12'd2));
    send_item(read_item(12'd3));
    send_item(read_item(12'd4095));

    // Individual count cuts a byte in the middle: only its first lane counts.
    write_individuals(13'd5);
    send_item(acc_item(8'h55, 10'd1, 1'b1, 1'b0));
    send_item(read_item(12'd4));
    send_item(read_item(12'd5));

    // No individuals at all; reads past the count still return stored values.
    write_individuals(13'd0);
    send_item(acc_item(8'hAA, 10'd0, 1'b1, 1'b0));
    send_item(read_item(12'd2));

    // Count above the store size behaves as the full store.
    write_individuals(13'd8191);
    send_item(acc_item(8'h00, 10'd1023, 1'b1, 1'b1));
    send_item(read_item(12'd4094));

    // Random: thirteen blocks of a hundred random items, a new individual count per block.
    for (int blk = 0; blk < 13; blk++) begin
      write_individuals(pick_individuals());
      // every fourth block runs back to back on both sides
      idle_on = (blk % 4) != 3;
      if (blk == 5) begin
        // Hold the output for a long stretch while reads keep coming, so the block
        // fills and stalls its input.
        idle_on      = 1'b0;
        hold_request = 300;
        repeat (40) send_item(read_item(gac_pkg::IND_W'($urandom_range(0, 72))));
        idle_on = 1'b1;
      end
      repeat (100) send_item(random_item());
    end

    // Tail: a fresh add on byte 2 with full count, read around it.
    write_individuals(gac_pkg::CFG_RESET);
    send_item(read_item(12'd8));
    send_item(read_item(12'd11));
    send_item(acc_item(8'h55, 10'd2, 1'b1, 1'b0));
    send_item(read_item(12'd9));
    send_item(read_item(12'd12));

    drain();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: well over four times the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== packed_genotype_allele_counter.f =====
+incdir+hdl
hdl/gac_pkg.sv
hdl/gac_ifs.sv
hdl/gac_front.sv
hdl/gac_queue.sv
hdl/gac_back.sv
hdl/packed_genotype_allele_counter.sv
test/genotype_tb_pkg.sv
test/testbench.sv
